// ===== hdl/gkg_pkg.sv =====
// Shared types, constants and elaboration-time tables for the Gaussian kernel generator.
// Used by gkg_mul, gkg_div and gaussian_kernel_generator_core; depends on nothing.
package gkg_pkg;

    // Sequencer states
    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_SQ,
        ST_SQ_CAP,
        ST_TAP,
        ST_DIV,
        ST_LOG,
        ST_LOG_CAP,
        ST_FRAC,
        ST_FRAC_CAP,
        ST_WEIGHT,
        ST_EMIT_RD,
        ST_EMIT_START,
        ST_EMIT_WAIT
    } gkg_state_t;

    // Exponent datapath widths
    localparam int SQ_W       = 32;   // sigma squared
    localparam int DIST_W     = 5;    // r*r + c*c, at most 18
    localparam int DIST_SHIFT = 17;   // d * 2^39 / s^2 = (d * 2^17) * 2^22 / s^2
    localparam int X_W        = 22;   // exponent in Q16, below 64.0
    localparam int Y_W        = 23;   // exponent times log2(e), Q16
    localparam int N_W        = 7;    // integer part of y
    localparam int F_W        = 16;   // fraction part of y
    localparam int M_W        = 33;   // mantissa, up to 2^32
    localparam int C_W        = 32;   // fraction power constants
    localparam int K_W        = 4;
    localparam int WT_W       = 35;   // rounding sum before the weight shift
    localparam int T_W        = 8;
    localparam int T_LIMIT    = 34;   // shifts at or above this give zero

    localparam logic [K_W-1:0] FRAC_LAST = K_W'(F_W - 1);

    // Shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] LOG2E_Q30 = 32'd1549082005;

    // Shared divider
    localparam int DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] X_STEPS = DIV_CNT_W'(X_W);

    typedef struct packed
    {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctrl_t;

    typedef logic [F_W-1:0][C_W-1:0] ctab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] probe;
        logic [63:0] rem;
        res   = '0;
        rem   = v;
        probe = 64'h4000_0000_0000_0000;
        while (probe > rem)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= res + probe)
            begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end
            else
            begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return res;
    endfunction

    // Entry k holds 2^32 * 2^(-2^-(k+1)), built by repeated square roots.
    function automatic ctab_t build_ctab();
        ctab_t       tab;
        logic [63:0] c;
        int          k;
        c = isqrt64(64'h8000_0000_0000_0000);
        for (k = 0; k < F_W; k++)
        begin
            tab[k] = c[C_W-1:0];
            c      = isqrt64(c << 32);
        end
        return tab;
    endfunction

    localparam ctab_t FRAC_TAB = build_ctab();

endpackage

// ===== hdl/gkg_mul.sv =====
// Shared registered multiplier of the Gaussian kernel generator.
// Depends on gkg_pkg for operand widths.
module gkg_mul
(
    input  logic                         clk,
    input  logic [gkg_pkg::MUL_A_W-1:0] a,
    input  logic [gkg_pkg::MUL_B_W-1:0] b,
    output logic [gkg_pkg::MUL_P_W-1:0] product
);
    import gkg_pkg::*;

    logic [MUL_P_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign product = product_reg;

endmodule

// ===== hdl/gkg_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on gkg_pkg for the control struct and the step counter width.
module gkg_div
#(
    parameter int DW = 32,
    parameter int QW = 22
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  gkg_pkg::div_ctrl_t ctrl,
    input  logic [DW-1:0]      divisor,
    input  logic [DW-1:0]      rem_init,
    input  logic [QW-1:0]      num_bits,
    output logic               done,
    output logic [QW-1:0]      quotient
);
    import gkg_pkg::*;

    logic                 run_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DW-1:0]        rem_reg;
    logic [DW-1:0]        div_reg;
    logic [QW-1:0]        bits_reg;
    logic [QW-1:0]        quo_reg;

    logic [DW:0]          shifted;
    logic [DW:0]          diff;
    logic                 fits;

    assign shifted = {rem_reg, bits_reg[QW-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = (shifted >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == DIV_CNT_W'(1));
            if (ctrl.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= ctrl.steps;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1))
                    run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg  <= rem_init;
            div_reg  <= divisor;
            bits_reg <= num_bits;
            quo_reg  <= '0;
        end
        else if (run_reg)
        begin
            // Keep the remainder below the divisor; shift in the next numerator bit
            rem_reg  <= fits ? diff[DW-1:0] : shifted[DW-1:0];
            bits_reg <= bits_reg << 1;
            quo_reg  <= {quo_reg[QW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/gaussian_kernel_generator_core.sv =====
// Top level of the Gaussian kernel generator: sequencer, weight memory and output register.
// Depends on gkg_pkg, gkg_mul and gkg_div.
//
// Usage
//   A request transfers half_width and sigma (unsigned Q4.12) at a rising edge where start
//   is high and busy is low. busy then stays high until the last coefficient is shown.
//   Every tap of the (2H+1)x(2H+1) window gets exp(-(r^2+c^2)/(2*sigma^2)), stored as a
//   raw weight and summed; the block then emits each weight over the sum as Q0.16,
//   row by row. Each result sits on coefficient, tap_row, tap_col and last for exactly
//   one cycle with valid high; the receiver cannot stall, so every result transfers.
// Sequencing
//   One shared multiplier and one shared bit-serial divider do the squaring, exponent,
//   fraction and normalizing arithmetic. Build, per tap: a 22-bit exponent division
//   (skipped at the centre) and a scaling by log2(e), then a pass over the fraction bits
//   of the exponent with a multiply and capture for each set bit; taps whose weight
//   underflows go straight to the store. Emit, per tap: a memory read, then a 17-bit
//   normalizing division.
//   A new request can transfer while last is shown, as busy is already low then.
// Reset
//   rst_n clears the sequencer, the tap counters, the sum and valid. The weight memory
//   is not cleared; every request writes all entries it later reads.
module gaussian_kernel_generator_core
#(
    parameter int MAX_HALF_WIDTH   = 3,
    parameter int WEIGHT_FRAC_BITS = 24,
    parameter int COEFF_FRAC_BITS  = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  half_width,
    input  logic [15:0] sigma,
    output logic        valid,
    output logic [15:0] coefficient,
    output logic [2:0]  tap_row,
    output logic [2:0]  tap_col,
    output logic        last
);
    import gkg_pkg::*;

    localparam int SIDE_MAX = 2 * MAX_HALF_WIDTH + 1;
    localparam int DEPTH    = SIDE_MAX * SIDE_MAX;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W    = WEIGHT_FRAC_BITS + $clog2(DEPTH);
    localparam int DW       = (SUM_W > SQ_W) ? SUM_W : SQ_W;
    localparam int NUM_W    = WEIGHT_FRAC_BITS + COEFF_FRAC_BITS + 1;
    localparam int T_OFS    = 32 - WEIGHT_FRAC_BITS;

    localparam logic [1:0]        MAX_HW2 = 2'(MAX_HALF_WIDTH);
    localparam logic [WT_W-1:0]   W_MAX   = (WT_W'(1) << WEIGHT_FRAC_BITS) - WT_W'(1);
    localparam logic [DIV_CNT_W-1:0] EMIT_STEPS = DIV_CNT_W'(COEFF_FRAC_BITS + 1);

    // Sequencer and counters
    gkg_state_t state_reg, state_next;
    logic [1:0]        hw_reg, hw_next;
    logic [2:0]        row_reg, row_next;
    logic [2:0]        col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              valid_reg, valid_next;

    // Per-request and per-tap working registers
    logic [15:0]       sigma_reg, sigma_next;
    logic [SQ_W-1:0]   sq_reg, sq_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [N_W-1:0]    n_reg, n_next;
    logic [F_W-1:0]    f_reg, f_next;
    logic [M_W-1:0]    m_reg, m_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              zero_reg, zero_next;

    // Output register
    logic [15:0]       coefficient_reg, coefficient_next;
    logic [2:0]        tap_row_reg, tap_row_next;
    logic [2:0]        tap_col_reg, tap_col_next;
    logic              last_reg, last_next;

    // Weight memory
    logic [WEIGHT_FRAC_BITS-1:0] wmem [DEPTH];
    logic [WEIGHT_FRAC_BITS-1:0] rd_data_reg;
    logic                        mem_we;

    // Shared units
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    div_ctrl_t          div_ctl;
    logic [DW-1:0]      div_divisor;
    logic [DW-1:0]      div_rem_init;
    logic [X_W-1:0]     div_bits;
    logic               div_done;
    logic [X_W-1:0]     div_quo;

    // Tap geometry
    logic [2:0]        hw3;
    logic [2:0]        side_m1;
    logic [1:0]        dr_abs;
    logic [1:0]        dc_abs;
    logic [DIST_W-1:0] tap_dist;
    logic              exp_ovf;
    logic              tap_is_last;
    logic [2:0]        row_adv;
    logic [2:0]        col_adv;

    // Exponent and weight arithmetic
    logic [MUL_P_W-1:0] y_full;
    logic [MUL_P_W-1:0] m_full;
    logic [T_W-1:0]     t_amt;
    logic [WT_W-1:0]    rnd;
    logic [WT_W-1:0]    wsum;
    logic [WT_W-1:0]    wshift;
    logic [WEIGHT_FRAC_BITS-1:0] w_val;

    // Normalization
    logic [NUM_W-1:0]           emit_num;
    logic [COEFF_FRAC_BITS-1:0] q_sat;

    gkg_mul u_mul
    (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p)
    );

    gkg_div
    #(
        .DW (DW),
        .QW (X_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctl),
        .divisor  (div_divisor),
        .rem_init (div_rem_init),
        .num_bits (div_bits),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Distance of the current tap from the centre
    assign hw3      = {1'b0, hw_reg};
    assign side_m1  = {hw_reg, 1'b0};
    assign dr_abs   = (row_reg >= hw3) ? 2'(row_reg - hw3) : 2'(hw3 - row_reg);
    assign dc_abs   = (col_reg >= hw3) ? 2'(col_reg - hw3) : 2'(hw3 - col_reg);
    assign tap_dist = DIST_W'(dr_abs) * DIST_W'(dr_abs) + DIST_W'(dc_abs) * DIST_W'(dc_abs);

    // Exponent reaches 64.0 when d * 2^17 >= s^2; sigma zero lands here too
    assign exp_ovf = ({{(SQ_W - DIST_W - DIST_SHIFT){1'b0}}, tap_dist, {DIST_SHIFT{1'b0}}}
                      >= sq_reg);

    assign tap_is_last = (row_reg == side_m1) && (col_reg == side_m1);
    assign col_adv     = (col_reg == side_m1) ? 3'd0 : col_reg + 3'd1;
    assign row_adv     = (col_reg == side_m1) ? row_reg + 3'd1 : row_reg;

    // Rounded products of the shared multiplier
    assign y_full = mul_p + (MUL_P_W'(1) << 29);
    assign m_full = mul_p + (MUL_P_W'(1) << 31);

    // Scale the mantissa by 2^-t with rounding, then saturate; large shifts and underflowed taps give zero
    assign t_amt  = T_W'(n_reg) + T_W'(T_OFS);
    assign rnd    = (t_amt == '0) ? '0 : (WT_W'(1) << (t_amt - T_W'(1)));
    assign wsum   = WT_W'(m_reg) + rnd;
    assign wshift = wsum >> t_amt;

    always_comb
    begin
        if (zero_reg || (t_amt >= T_W'(T_LIMIT)))
            w_val = '0;
        else if (wshift > W_MAX)
            w_val = W_MAX[WEIGHT_FRAC_BITS-1:0];
        else
            w_val = wshift[WEIGHT_FRAC_BITS-1:0];
    end

    // Numerator w * 2^CFB + S/2 for the normalizing division
    assign emit_num = NUM_W'({rd_data_reg, {COEFF_FRAC_BITS{1'b0}}})
                    + NUM_W'(sum_reg >> 1);
    assign q_sat    = div_quo[COEFF_FRAC_BITS] ? {COEFF_FRAC_BITS{1'b1}}
                                               : div_quo[COEFF_FRAC_BITS-1:0];

    // Multiplier operand select
    always_comb
    begin
        case (state_reg)
            ST_SQ:
            begin
                mul_a = MUL_A_W'(sigma_reg);
                mul_b = MUL_B_W'(sigma_reg);
            end
            ST_LOG:
            begin
                mul_a = MUL_A_W'(x_reg);
                mul_b = LOG2E_Q30;
            end
            default:
            begin
                mul_a = m_reg;
                mul_b = FRAC_TAB[k_reg];
            end
        endcase
    end

    // Next state and datapath control
    always_comb
    begin
        state_next       = state_reg;
        hw_next          = hw_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        addr_next        = addr_reg;
        sum_next         = sum_reg;
        valid_next       = 1'b0;
        sigma_next       = sigma_reg;
        sq_next          = sq_reg;
        x_next           = x_reg;
        n_next           = n_reg;
        f_next           = f_reg;
        m_next           = m_reg;
        k_next           = k_reg;
        zero_next        = zero_reg;
        coefficient_next = coefficient_reg;
        tap_row_next     = tap_row_reg;
        tap_col_next     = tap_col_reg;
        last_next        = last_reg;
        mem_we           = 1'b0;
        div_ctl          = '0;
        div_divisor      = DW'(sq_reg);
        div_rem_init     = DW'({tap_dist, {DIST_SHIFT{1'b0}}});
        div_bits         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    hw_next    = (half_width > MAX_HW2) ? MAX_HW2 : half_width;
                    sigma_next = sigma;
                    row_next   = '0;
                    col_next   = '0;
                    addr_next  = '0;
                    sum_next   = '0;
                    state_next = ST_SQ;
                end
            end

            ST_SQ:
            begin
                state_next = ST_SQ_CAP;
            end

            ST_SQ_CAP:
            begin
                sq_next    = mul_p[SQ_W-1:0];
                state_next = ST_TAP;
            end

            ST_TAP:
            begin
                zero_next = 1'b0;
                x_next    = '0;
                if (tap_dist == '0)
                begin
                    state_next = ST_LOG;
                end
                else if (exp_ovf)
                begin
                    // Weight underflows; skip straight to the store
                    zero_next  = 1'b1;
                    state_next = ST_WEIGHT;
                end
                else
                begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = X_STEPS;
                    state_next    = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (div_done)
                begin
                    x_next     = div_quo;
                    state_next = ST_LOG;
                end
            end

            ST_LOG:
            begin
                state_next = ST_LOG_CAP;
            end

            ST_LOG_CAP:
            begin
                n_next     = y_full[30 + Y_W - 1 -: N_W];
                f_next     = y_full[30 + F_W - 1 -: F_W];
                m_next     = M_W'(1) << 32;
                k_next     = '0;
                state_next = ST_FRAC;
            end

            ST_FRAC:
            begin
                if (f_reg[F_W-1])
                begin
                    state_next = ST_FRAC_CAP;
                end
                else
                begin
                    f_next = f_reg << 1;
                    if (k_reg == FRAC_LAST)
                        state_next = ST_WEIGHT;
                    else
                        k_next = k_reg + K_W'(1);
                end
            end

            ST_FRAC_CAP:
            begin
                m_next = m_full[32 +: M_W];
                f_next = f_reg << 1;
                if (k_reg == FRAC_LAST)
                begin
                    state_next = ST_WEIGHT;
                end
                else
                begin
                    k_next     = k_reg + K_W'(1);
                    state_next = ST_FRAC;
                end
            end

            ST_WEIGHT:
            begin
                mem_we   = 1'b1;
                sum_next = sum_reg + SUM_W'(w_val);
                if (tap_is_last)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    addr_next  = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    row_next   = row_adv;
                    col_next   = col_adv;
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_TAP;
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_START;
            end

            ST_EMIT_START:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = EMIT_STEPS;
                div_divisor   = DW'(sum_reg);
                div_rem_init  = DW'(emit_num >> (COEFF_FRAC_BITS + 1));
                div_bits      = X_W'(emit_num[COEFF_FRAC_BITS:0])
                                << (X_W - COEFF_FRAC_BITS - 1);
                state_next    = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (div_done)
                begin
                    coefficient_next = 16'(q_sat);
                    tap_row_next     = row_reg;
                    tap_col_next     = col_reg;
                    last_next        = tap_is_last;
                    valid_next       = 1'b1;
                    if (tap_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_adv;
                        col_next   = col_adv;
                        addr_next  = addr_reg + ADDR_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hw_reg    <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            addr_reg  <= '0;
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hw_reg    <= hw_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            addr_reg  <= addr_next;
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sigma_reg       <= sigma_next;
        sq_reg          <= sq_next;
        x_reg           <= x_next;
        n_reg           <= n_next;
        f_reg           <= f_next;
        m_reg           <= m_next;
        k_reg           <= k_next;
        zero_reg        <= zero_next;
        coefficient_reg <= coefficient_next;
        tap_row_reg     <= tap_row_next;
        tap_col_reg     <= tap_col_next;
        last_reg        <= last_next;
    end

    // Raw weight store: write during build, registered read during emit
    always_ff @(posedge clk)
    begin
        if (mem_we)
            wmem[addr_reg] <= w_val;
        rd_data_reg <= wmem[addr_reg];
    end

    assign busy        = (state_reg != ST_IDLE);
    assign valid       = valid_reg;
    assign coefficient = coefficient_reg;
    assign tap_row     = tap_row_reg;
    assign tap_col     = tap_col_reg;
    assign last        = last_reg;

`ifndef SYNTH
    a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(state_reg == ST_EMIT_WAIT))
        else $error("result strobe without a finished normalizing division");

    a_last_frees_block: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> !busy)
        else $error("block still busy while the last coefficient is shown");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request transfer did not make the block busy");

    a_sum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT_START |-> sum_reg != '0)
        else $error("normalizing by a zero weight sum");
`endif

endmodule

// ===== tb/tb_gaussian_kernel_generator_core.sv =====
// Self-checking testbench for gaussian_kernel_generator_core: a directed table, then random requests.
// Needs only the RTL (gkg_pkg, gkg_mul, gkg_div, gaussian_kernel_generator_core).
`timescale 1ns / 100ps

module tb_gaussian_kernel_generator_core;

    localparam int          HALF_PERIOD  = 2;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_REQS  = 241;
    localparam int          IDLE_LIMIT   = 20000;   // longer than the quiet build phase of a 7x7 kernel
    localparam int          W_FRAC       = 24;
    localparam int          C_FRAC       = 16;
    localparam logic [63:0] LOG2E_Q30    = 64'd1549082005;
    localparam logic [63:0] W_MAX        = (64'd1 << W_FRAC) - 64'd1;
    localparam logic [63:0] C_MAX        = (64'd1 << C_FRAC) - 64'd1;

    // One row of the directed table. When fixed is set, the kernel is known by
    // eye: centre tap gets centre_coeff, every other tap gets rim_coeff.
    typedef struct packed
    {
        logic [1:0]  hw;
        logic [15:0] sg;
        logic        fixed;
        logic [15:0] centre_coeff;
        logic [15:0] rim_coeff;
    } kernel_req_t;

    typedef struct packed
    {
        logic [15:0] coeff;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        last;
    } tap_result_t;

    localparam int DIR_N = 19;
    localparam kernel_req_t DIR_TAB [DIR_N] = '{
        // single tap: the one coefficient is 1.0, saturated
        '{2'd0, 16'h1000, 1'b1, 16'hFFFF, 16'h0000},
        '{2'd0, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
        '{2'd0, 16'hFFFF, 1'b1, 16'hFFFF, 16'h0000},
        // sigma zero: only the centre carries weight
        '{2'd3, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
        '{2'd1, 16'h0000, 1'b1, 16'hFFFF, 16'h0000},
        // smallest sigma: every off-centre exponent underflows
        '{2'd3, 16'h0001, 1'b1, 16'hFFFF, 16'h0000},
        '{2'd2, 16'h0001, 1'b1, 16'hFFFF, 16'h0000},
        '{2'd1, 16'h1000, 1'b0, 16'h0000, 16'h0000},
        '{2'd2, 16'h1000, 1'b0, 16'h0000, 16'h0000},
        '{2'd3, 16'h1000, 1'b0, 16'h0000, 16'h0000},
        '{2'd3, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        '{2'd3, 16'h8000, 1'b0, 16'h0000, 16'h0000},
        '{2'd1, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        '{2'd2, 16'h0800, 1'b0, 16'h0000, 16'h0000},
        '{2'd3, 16'h0400, 1'b0, 16'h0000, 16'h0000},
        '{2'd3, 16'h0100, 1'b0, 16'h0000, 16'h0000},
        '{2'd2, 16'h5555, 1'b0, 16'h0000, 16'h0000},
        '{2'd1, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
        '{2'd3, 16'h2D41, 1'b0, 16'h0000, 16'h0000}
    };

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  half_width;
    logic [15:0] sigma;
    logic        valid;
    logic [15:0] coefficient;
    logic [2:0]  tap_row;
    logic [2:0]  tap_col;
    logic        last;

    tap_result_t expected_taps [$];
    logic [63:0] frac_pow [1:16];   // 2^32 * 2^(-2^-k)
    int          mismatches;
    int          quiet_cycles;

    gaussian_kernel_generator_core i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .half_width  (half_width),
        .sigma       (sigma),
        .valid       (valid),
        .coefficient (coefficient),
        .tap_row     (tap_row),
        .tap_col     (tap_col),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #HALF_PERIOD clk = ~clk;

    // Floor square root, one result bit per pass from the top down.
    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] acc;
        logic [63:0] trial;
        acc = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= v)
                acc = trial;
        end
        return acc;
    endfunction

    // Raw weight of a tap at squared distance d, Q0.24, saturated.
    function automatic logic [63:0] tap_weight(input int unsigned d, input logic [15:0] s);
        logic [63:0]  expo;
        logic [63:0]  expo2;
        logic [127:0] mant;
        logic [63:0]  wt;
        logic [15:0]  frac;
        int unsigned  ipart;
        int unsigned  shift;
        if (d == 0)
            expo = '0;
        else if (s == 16'd0)
            return '0;
        else
            expo = (64'(d) << 39) / (64'(s) * 64'(s));
        if (expo >= (64'd64 << 16))
            return '0;
        // Move to base 2, split into integer and fraction.
        expo2 = (expo * LOG2E_Q30 + (64'd1 << 29)) >> 30;
        ipart = int'(expo2 >> 16);
        frac  = expo2[15:0];
        mant  = 128'd1 << 32;
        for (int k = 1; k <= 16; k++)
        begin
            if (frac[16-k])
                mant = (mant * frac_pow[k] + (128'd1 << 31)) >> 32;
        end
        shift = ipart + 32 - W_FRAC;
        if (shift >= 64)
            return '0;
        wt = (mant[63:0] + (64'd1 << (shift - 1))) >> shift;
        return (wt > W_MAX) ? W_MAX : wt;
    endfunction

    // Build the whole kernel for one request and queue its taps in emit order.
    task automatic queue_kernel(input logic [1:0] hw, input logic [15:0] s);
        logic [63:0] weights [49];
        logic [63:0] wsum;
        logic [63:0] q;
        int          side;
        int          total;
        int          dr;
        int          dc;
        tap_result_t tap;
        side  = 2 * int'(hw) + 1;
        total = side * side;
        wsum  = '0;
        for (int i = 0; i < total; i++)
        begin
            dr         = i / side - int'(hw);
            dc         = i % side - int'(hw);
            weights[i] = tap_weight(dr * dr + dc * dc, s);
            wsum       = wsum + weights[i];
        end
        for (int i = 0; i < total; i++)
        begin
            q         = ((weights[i] << C_FRAC) + (wsum >> 1)) / wsum;
            tap.coeff = (q > C_MAX) ? C_MAX[15:0] : q[15:0];
            tap.row   = 3'(i / side);
            tap.col   = 3'(i % side);
            tap.last  = (i == total - 1);
            expected_taps.push_back(tap);
        end
    endtask

    // Queue a kernel read off by eye: one value at the centre, another elsewhere.
    task automatic queue_fixed_kernel(input kernel_req_t req);
        int          side;
        int          total;
        tap_result_t tap;
        side  = 2 * int'(req.hw) + 1;
        total = side * side;
        for (int i = 0; i < total; i++)
        begin
            tap.coeff = (i == total / 2) ? req.centre_coeff : req.rim_coeff;
            tap.row   = 3'(i / side);
            tap.col   = 3'(i % side);
            tap.last  = (i == total - 1);
            expected_taps.push_back(tap);
        end
    endtask

    task automatic report(input string what, input int want, input int got);
        mismatches++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    // Drive one request and return at the edge where it transfers.
    // Drop start for gap cycles (with junk on the fields); on drain, also hold
    // off until every queued tap has come out.
    task automatic transfer_request(input logic [1:0] hw, input logic [15:0] s,
                                    input int gap, input bit drain);
        int idle;
        idle = (drain && gap == 0) ? 1 : gap;
        if (idle > 0)
        begin
            start      <= 1'b0;
            half_width <= 2'($urandom);
            sigma      <= 16'($urandom);
            repeat (idle) @(posedge clk);
            if (drain)
            begin
                while (expected_taps.size() != 0)
                    @(posedge clk);
            end
        end
        start      <= 1'b1;
        half_width <= hw;
        sigma      <= s;
        // Hold the request until busy is seen low at an edge.
        do
            @(posedge clk);
        while (busy);
    endtask

    // Checker: every strobed result must match the oldest queued tap.
    always @(posedge clk)
    begin
        tap_result_t want;
        if (rst_n && valid)
        begin
            if (expected_taps.size() == 0)
            begin
                report("unexpected result", 0, 1);
            end
            else
            begin
                want = expected_taps.pop_front();
                if (coefficient !== want.coeff)
                    report("coefficient", want.coeff, coefficient);
                if (tap_row !== want.row)
                    report("tap_row", want.row, tap_row);
                if (tap_col !== want.col)
                    report("tap_col", want.col, tap_col);
                if (last !== want.last)
                    report("last", want.last, last);
            end
        end
    end

    // Watchdog: count cycles in which neither side transfers anything.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random requests, drain, verdict.
    initial
    begin
        logic [63:0] c;
        logic [1:0]  hw;
        logic [15:0] s;
        int          pick;
        int          gap;
        mismatches   = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        half_width   = '0;
        sigma        = '0;

        // Fraction power constants by repeated square roots.
        c = root_floor(64'h8000_0000_0000_0000);
        for (int k = 1; k <= 16; k++)
        begin
            frac_pow[k] = c;
            c           = root_floor(c << 32);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: fixed rows carry their own answer, the rest go
        // through the predictor.
        for (int i = 0; i < DIR_N; i++)
        begin
            transfer_request(DIR_TAB[i].hw, DIR_TAB[i].sg, $urandom_range(0, 7), 1'b0);
            if (DIR_TAB[i].fixed)
                queue_fixed_kernel(DIR_TAB[i]);
            else
                queue_kernel(DIR_TAB[i].hw, DIR_TAB[i].sg);
        end

        // Random part: small windows dominate to keep the run short.
        for (int i = 0; i < RANDOM_REQS; i++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 5)
                hw = 2'd0;
            else if (pick < 11)
                hw = 2'd1;
            else if (pick < 17)
                hw = 2'd2;
            else
                hw = 2'd3;
            pick = $urandom_range(0, 15);
            if (pick == 0)
                s = 16'h0000;
            else if (pick == 1)
                s = 16'hFFFF;
            else if (pick < 8)
                s = 16'($urandom_range(16'h0200, 16'h3000));   // usual filter widths
            else
                s = 16'($urandom);
            // Every third block of 20 requests runs back to back.
            gap = ((i / 20) % 3 == 1) ? 0 : $urandom_range(0, 7);
            transfer_request(hw, s, gap, (i == 0) || (i % 64 == 32));
            queue_kernel(hw, s);
        end

        // Release start, let the last kernel come out, then give some slack.
        start <= 1'b0;
        while (expected_taps.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
